@@ design/ppd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and codes of the periodic priority task dispatcher
// Request and result beat layouts, command and status codes, sequencer
// states and the control group that drives the sorted dispatch list.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

	// Dispatch list length: most run beats one run command can produce
	localparam int MAX_RESULTS = 16;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_RUN = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic               command;
		logic [31:0]        now_ms;
		logic [30:0]        period;
		logic [31:0]        first_due;
		logic signed [15:0] prio_value;
	} request_t;

	typedef struct packed {
		logic       result_kind;
		logic [3:0] task_index;
		logic       status;
		logic       last_item;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic pop;
	} sort_cmd_t;

endpackage

`default_nettype wire

@@ design/periodic_priority_task_dispatcher_top.sv @@
// ----------------------------------------------------------------------------
// periodic_priority_task_dispatcher_top: periodic task dispatcher
// Task table in RAM, one shared add/compare unit swept over the table under
// a small sequencer, and a sorted list that orders due tasks by priority.
// ----------------------------------------------------------------------------
//
//  channel   ports                        handshake
//  -------   --------------------------   -----------------------------------
//  request   start, busy, request         beat taken when start && !busy
//  result    result_valid, result         one-cycle strobe, no backpressure
//
//  Add: the acknowledge beat follows on the next cycle.
//  Run: a sweep reads one task per cycle through the shared due-time
//  adder/comparator, then one result beat per due task up to MAX_RESULTS
//  (no beat if none is due).
//  Reset clears task_count and the sequencer; the task table is not cleared.
//  The receiver cannot stall: every beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_priority_task_dispatcher_top #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire ppd_pkg::request_t request,
	output logic                   result_valid,
	output ppd_pkg::result_t       result
);

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	ppd_pkg::state_t    state_q, state_d;
	ppd_pkg::sort_cmd_t sort_cmd;
	ppd_pkg::result_t   result_q;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_ptr_q;
	logic [31:0]        now_q;
	logic               chk_s1;
	logic [IW-1:0]      idx_s1;
	logic               result_valid_q;

	logic               accept, do_add, do_run, full, more;
	logic               issue, emit_fire, is_due;
	logic [31:0]        due_rdata, due_sum, due_wdata;
	logic [30:0]        period_rdata;
	logic signed [15:0] prio_rdata;
	logic               due_we;
	logic [IW-1:0]      due_waddr;
	logic               head_valid, next_valid;
	logic [IW-1:0]      head_idx;

	assign accept = start && !busy;
	assign do_add = accept && (request.command == ppd_pkg::CMD_ADD);
	assign do_run = accept && (request.command == ppd_pkg::CMD_RUN);
	assign full   = (count_q == CW'(MAX_TASKS));
	assign more   = (rd_ptr_q != count_q);

	// shared due-time unit
	assign is_due  = (due_rdata <= now_q);
	assign due_sum = due_rdata + {1'b0, period_rdata};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppd_pkg::ST_IDLE: begin
				if (do_run) state_d = ppd_pkg::ST_SWEEP;
			end
			ppd_pkg::ST_SWEEP: begin
				if (!more && !chk_s1) state_d = ppd_pkg::ST_EMIT;
			end
			ppd_pkg::ST_EMIT: begin
				if (!head_valid || !next_valid) state_d = ppd_pkg::ST_IDLE;
			end
			default: state_d = ppd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy            = (state_q != ppd_pkg::ST_IDLE);
		issue           = (state_q == ppd_pkg::ST_SWEEP) && more;
		emit_fire       = (state_q == ppd_pkg::ST_EMIT) && head_valid;
		sort_cmd.clear  = do_run;
		sort_cmd.insert = chk_s1 && is_due;
		sort_cmd.pop    = emit_fire;
	end

	assign due_we    = (do_add && !full) || sort_cmd.insert;
	assign due_waddr = do_add ? count_q[IW-1:0] : idx_s1;
	assign due_wdata = do_add ? request.first_due : due_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ppd_pkg::ST_IDLE;
			count_q        <= '0;
			rd_ptr_q       <= '0;
			chk_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			chk_s1         <= issue;
			result_valid_q <= do_add || emit_fire;
			if (do_add && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (do_run) begin
				rd_ptr_q <= '0;
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_run) begin
			now_q <= request.now_ms;
		end
		if (issue) begin
			idx_s1 <= rd_ptr_q[IW-1:0];
		end
		if (do_add) begin
			result_q.result_kind <= ppd_pkg::KIND_ACK;
			result_q.task_index  <= full ? 4'd0 : 4'(count_q[IW-1:0]);
			result_q.status      <= full ? ppd_pkg::STATUS_FULL : ppd_pkg::STATUS_OK;
			result_q.last_item   <= 1'b1;
		end else if (emit_fire) begin
			result_q.result_kind <= ppd_pkg::KIND_RUN;
			result_q.task_index  <= 4'(head_idx);
			result_q.status      <= ppd_pkg::STATUS_OK;
			result_q.last_item   <= !next_valid;
		end
	end

	ppd_ram #(.WIDTH(31), .DEPTH(MAX_TASKS)) u_period_ram (
		.clk   (clk),
		.we    (do_add && !full),
		.waddr (count_q[IW-1:0]),
		.wdata (request.period),
		.raddr (rd_ptr_q[IW-1:0]),
		.rdata (period_rdata)
	);

	ppd_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_due_ram (
		.clk   (clk),
		.we    (due_we),
		.waddr (due_waddr),
		.wdata (due_wdata),
		.raddr (rd_ptr_q[IW-1:0]),
		.rdata (due_rdata)
	);

	ppd_ram #(.WIDTH(16), .DEPTH(MAX_TASKS)) u_prio_ram (
		.clk   (clk),
		.we    (do_add && !full),
		.waddr (count_q[IW-1:0]),
		.wdata (request.prio_value),
		.raddr (rd_ptr_q[IW-1:0]),
		.rdata (prio_rdata)
	);

	ppd_sorter #(.IDX_W(IW)) u_sorter (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (sort_cmd),
		.ins_idx    (idx_s1),
		.ins_prio   (prio_rdata),
		.head_valid (head_valid),
		.head_idx   (head_idx),
		.next_valid (next_valid)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a beat shown while idle closes its command
	a_idle_beat_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !busy |-> result.last_item)
		else $error("non-final beat while idle");

	a_add_ack: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.command == ppd_pkg::CMD_ADD |=>
		result_valid && result.result_kind == ppd_pkg::KIND_ACK)
		else $error("add without acknowledge beat");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TASKS))
		else $error("task count above table size");

endmodule

`default_nettype wire

@@ design/ppd_ram.sv @@
// ----------------------------------------------------------------------------
// ppd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/ppd_sorter.sv @@
// ----------------------------------------------------------------------------
// ppd_sorter: sorted dispatch list
// A row of cells kept in descending priority. An insert goes ahead of the
// first cell whose priority is not above it; a cell pushed off the end is
// dropped. Pop shifts the row toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_sorter #(
	parameter int IDX_W = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ppd_pkg::sort_cmd_t cmd,
	input  wire logic [IDX_W-1:0]   ins_idx,
	input  wire logic signed [15:0] ins_prio,
	output logic                    head_valid,
	output logic [IDX_W-1:0]        head_idx,
	output logic                    next_valid
);

	localparam int N = ppd_pkg::MAX_RESULTS;

	logic               valid_q [N];
	logic [IDX_W-1:0]   idx_q   [N];
	logic signed [15:0] prio_q  [N];

	logic               valid_d [N];
	logic [IDX_W-1:0]   idx_d   [N];
	logic signed [15:0] prio_d  [N];
	logic               stays   [N];

	always_comb begin
		for (int k = 0; k < N; k++) begin
			stays[k] = valid_q[k] && (prio_q[k] > ins_prio);
		end
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			valid_d[k] = valid_q[k];
			idx_d[k]   = idx_q[k];
			prio_d[k]  = prio_q[k];
		end
		if (cmd.clear) begin
			for (int k = 0; k < N; k++) begin
				valid_d[k] = 1'b0;
			end
		end else if (cmd.insert) begin
			if (!stays[0]) begin
				valid_d[0] = 1'b1;
				idx_d[0]   = ins_idx;
				prio_d[0]  = ins_prio;
			end
			for (int k = 1; k < N; k++) begin
				if (!stays[k]) begin
					if (stays[k-1]) begin
						valid_d[k] = 1'b1;
						idx_d[k]   = ins_idx;
						prio_d[k]  = ins_prio;
					end else begin
						// shift the tail down one cell
						valid_d[k] = valid_q[k-1];
						idx_d[k]   = idx_q[k-1];
						prio_d[k]  = prio_q[k-1];
					end
				end
			end
		end else if (cmd.pop) begin
			for (int k = 0; k < N - 1; k++) begin
				valid_d[k] = valid_q[k+1];
				idx_d[k]   = idx_q[k+1];
				prio_d[k]  = prio_q[k+1];
			end
			valid_d[N-1] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < N; k++) begin
				valid_q[k] <= valid_d[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			idx_q[k]  <= idx_d[k];
			prio_q[k] <= prio_d[k];
		end
	end

	assign head_valid = valid_q[0];
	assign head_idx   = idx_q[0];
	assign next_valid = valid_q[1];

endmodule

`default_nettype wire
